// ----- design/paf_pkg.sv -----
// ----------------------------------------------------------------------------
// paf_pkg: shared definitions of the packet ACL filter
// Codes, rule layout, controller states, the command and status groups that
// join controller and datapath, and the IPv4 prefix mask helper.
// ----------------------------------------------------------------------------
package paf_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_FIELD = 2'd2;

    // Result status codes
    localparam logic [2:0] STATUS_PASSED   = 3'd0;
    localparam logic [2:0] STATUS_FILTERED = 3'd1;
    localparam logic [2:0] STATUS_STORED   = 3'd2;
    localparam logic [2:0] STATUS_PRESENT  = 3'd3;
    localparam logic [2:0] STATUS_FULL     = 3'd4;

    // Header field keys
    localparam logic [3:0] KEY_IPPROTO  = 4'd5;
    localparam logic [3:0] KEY_IPSRC    = 4'd6;
    localparam logic [3:0] KEY_IPDST    = 4'd7;
    localparam logic [3:0] KEY_UDP_SRC  = 4'd8;
    localparam logic [3:0] KEY_TCP_SRC  = 4'd10;
    localparam logic [3:0] KEY_TCP_DST  = 4'd11;

    // IP protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_MAX = 8'd255;

    localparam int         IPV4_BITS  = 32;
    localparam logic [5:0] PREFIX_MAX = 6'(IPV4_BITS);

    // One stored rule
    typedef struct packed {
        logic [3:0]  key;
        logic [5:0]  prefix;
        logic [47:0] value;
    } rule_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic idle;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_fire;
        logic start_scan;
        logic scan_last;
        logic need_result;
        logic out_free;
    } dp_status_t;

    // Network mask for an IPv4 prefix length of at most 32 bits.
    function automatic logic [31:0] ipv4_mask(input logic [5:0] prefix);
        logic [31:0] mask;
        mask = '0;
        if (prefix != 6'd0)
        begin
            mask = 32'hFFFF_FFFF << (PREFIX_MAX - prefix);
        end
        return mask;
    endfunction

endpackage

// ----- design/paf_if.sv -----
// ----------------------------------------------------------------------------
// paf_if: channel interfaces of the packet ACL filter
// The item channel carries rule commands and header fields; the verdict
// channel carries one result per rule addition or per finished packet.
// ----------------------------------------------------------------------------
interface paf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        list_sel;
    logic [3:0]  field_key;
    logic [47:0] field_value;
    logic [5:0]  prefix_len;
    logic        last_field;

    modport source (output valid, kind, list_sel, field_key, field_value, prefix_len,
                    last_field, input ready);
    modport sink   (input valid, kind, list_sel, field_key, field_value, prefix_len,
                    last_field, output ready);
endinterface

interface paf_verdict_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       white_hit;
    logic       black_hit;

    modport source (output valid, status, white_hit, black_hit, input ready);
    modport sink   (input valid, status, white_hit, black_hit, output ready);
endinterface

// ----- design/packet_acl_filter_unit.sv -----
// ----------------------------------------------------------------------------
// packet_acl_filter_unit: header-field packet filter with white and black lists
// Top level joining the sequencing controller and the rule datapath.
// ----------------------------------------------------------------------------
// Usage:
// The item channel takes one transaction per rule addition, list clear or
// header field. A rule addition gives one verdict transaction with the store
// status; a header field marked last gives the packet verdict with the hit
// flags; clears and other fields give nothing.
// Clears and unused kinds start no scan. A rule addition or header field
// scans both lists together, one entry of each per cycle through the read
// port of each rule memory, then passes a drain state and a commit state
// before the next transaction is accepted; its result is loaded into the
// output register at the commit.
// The verdict is held in an output register. While the receiver stalls the
// block still takes and scans the next transaction, and holds its commit
// until the waiting result has been taken.
// Reset empties both lists and clears the packet state; the rule memories
// are not cleared, since only entries below a list's count take part in a match.
// ----------------------------------------------------------------------------
module packet_acl_filter_unit #(
    parameter int RULES_PER_LIST = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    paf_item_if.sink      item,
    paf_verdict_if.source verdict
);

    paf_pkg::ctrl_cmd_t  cmd;
    paf_pkg::dp_status_t status;

    // Sequencing
    paf_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Rule storage and matching
    paf_datapath #(
        .RULES_PER_LIST (RULES_PER_LIST)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .verdict (verdict),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ----- design/paf_controller.sv -----
// ----------------------------------------------------------------------------
// paf_controller: sequencing state machine of the packet ACL filter
// Steps each accepted rule or header field through a scan of both rule
// lists, a drain state for the last read, and a commit of the outcome.
// ----------------------------------------------------------------------------
module paf_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  paf_pkg::dp_status_t status,
    output paf_pkg::ctrl_cmd_t  cmd
);

    paf_pkg::state_t state_reg;
    paf_pkg::state_t state_next;
    logic            commit_ok;

    // The commit waits only when a result is due and the output holds a verdict that is not being taken.
    assign commit_ok = !status.need_result || status.out_free;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= paf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            paf_pkg::ST_IDLE:
            begin
                if (status.in_fire && status.start_scan)
                begin
                    state_next = paf_pkg::ST_SCAN;
                end
            end
            paf_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = paf_pkg::ST_DRAIN;
                end
            end
            paf_pkg::ST_DRAIN:
            begin
                state_next = paf_pkg::ST_COMMIT;
            end
            paf_pkg::ST_COMMIT:
            begin
                if (commit_ok)
                begin
                    state_next = paf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = paf_pkg::ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            paf_pkg::ST_IDLE:   cmd.idle   = 1'b1;
            paf_pkg::ST_SCAN:   cmd.scan   = 1'b1;
            paf_pkg::ST_DRAIN:  cmd        = '0;
            paf_pkg::ST_COMMIT: cmd.commit = commit_ok;
            default:            cmd        = '0;
        endcase
    end

endmodule

// ----- design/paf_datapath.sv -----
// ----------------------------------------------------------------------------
// paf_datapath: rule memories, packet state and result register
// Holds the whitelist and blacklist memories, reads one entry of each per
// cycle during a scan, accumulates matches, and applies the outcome.
// ----------------------------------------------------------------------------
module paf_datapath #(
    parameter int RULES_PER_LIST = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    paf_item_if.sink             item,
    paf_verdict_if.source        verdict,
    input  paf_pkg::ctrl_cmd_t   cmd,
    output paf_pkg::dp_status_t  status
);

    localparam int IDX_W = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
    localparam int CNT_W = $clog2(RULES_PER_LIST + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RULES_PER_LIST);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RULES_PER_LIST - 1);

    // Rule memories
    paf_pkg::rule_t white_mem [RULES_PER_LIST];
    paf_pkg::rule_t black_mem [RULES_PER_LIST];

    // Latched operation
    logic [1:0]  op_kind_reg;
    logic        op_list_reg;
    logic [3:0]  op_key_reg;
    logic [47:0] op_value_reg;
    logic [5:0]  op_prefix_reg;
    logic        op_check_reg;
    logic        op_last_reg;

    // Scan pipeline
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_valid_reg;
    paf_pkg::rule_t   rd_white_reg;
    paf_pkg::rule_t   rd_black_reg;
    logic             hit_w_reg;
    logic             hit_w_next;
    logic             hit_b_reg;
    logic             hit_b_next;

    // Lists and packet state
    logic [CNT_W-1:0] white_count_reg;
    logic [CNT_W-1:0] white_count_next;
    logic [CNT_W-1:0] black_count_reg;
    logic [CNT_W-1:0] black_count_next;
    logic             white_seen_reg;
    logic             white_seen_next;
    logic             black_seen_reg;
    logic             black_seen_next;
    logic [7:0]       proto_reg;
    logic [7:0]       proto_next;
    logic             proto_known_reg;
    logic             proto_known_next;

    // Result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [2:0]       out_status_reg;
    logic [2:0]       out_status_next;
    logic             out_white_reg;
    logic             out_white_next;
    logic             out_black_reg;
    logic             out_black_next;

    // Input decode
    logic        in_fire;
    logic        in_ipv4;
    logic        in_port;
    logic        in_udp;
    logic        in_tcp;
    logic [3:0]  in_eff_key;
    logic        in_check;
    logic [47:0] in_value;
    logic [5:0]  in_prefix;

    // Commit decode
    logic             is_add;
    logic             is_field;
    logic [CNT_W-1:0] sel_count;
    logic             dup;
    logic             full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    paf_pkg::rule_t   wr_rule;
    logic             ws;
    logic             bs;
    logic             white_live;
    logic             black_live;
    logic [7:0]       proto_sat;

    // Compare one stored rule: exact for additions, header match for fields.
    function automatic logic entry_match(
        input paf_pkg::rule_t e,
        input logic           add,
        input logic [3:0]     key,
        input logic [47:0]    value,
        input logic [5:0]     prefix
    );
        logic v4;
        logic hit;
        v4 = (key == paf_pkg::KEY_IPSRC) || (key == paf_pkg::KEY_IPDST);
        if (add)
        begin
            hit = (e.key == key) && (e.value == value) && (e.prefix == prefix);
        end
        else if (e.key != key)
        begin
            hit = 1'b0;
        end
        else if (v4)
        begin
            hit = ((e.value[31:0] ^ value[31:0]) & paf_pkg::ipv4_mask(e.prefix)) == 32'd0;
        end
        else
        begin
            hit = (e.value == value);
        end
        return hit;
    endfunction

    // Handshake and status towards the controller
    assign item.ready         = cmd.idle;
    assign in_fire            = item.valid && cmd.idle;
    assign status.in_fire     = in_fire;
    assign status.start_scan  = (item.kind == paf_pkg::KIND_ADD) ||
                                (item.kind == paf_pkg::KIND_FIELD);
    assign status.scan_last   = (idx_reg == IDX_LAST);
    assign status.need_result = is_add || (is_field && op_last_reg);
    assign status.out_free    = !out_valid_reg || verdict.ready;

    assign verdict.valid     = out_valid_reg;
    assign verdict.status    = out_status_reg;
    assign verdict.white_hit = out_white_reg;
    assign verdict.black_hit = out_black_reg;

    // Normalise the incoming value and resolve port keys by packet protocol.
    always_comb
    begin
        in_ipv4 = (item.field_key == paf_pkg::KEY_IPSRC) ||
                  (item.field_key == paf_pkg::KEY_IPDST);
        in_port = (item.field_key >= paf_pkg::KEY_UDP_SRC) &&
                  (item.field_key <= paf_pkg::KEY_TCP_DST);
        in_udp  = proto_known_reg && (proto_reg == paf_pkg::PROTO_UDP);
        in_tcp  = proto_known_reg && (proto_reg == paf_pkg::PROTO_TCP);
        in_value  = in_ipv4 ? {16'd0, item.field_value[31:0]} : item.field_value;
        in_prefix = '0;
        if (in_ipv4)
        begin
            in_prefix = (item.prefix_len > paf_pkg::PREFIX_MAX) ? paf_pkg::PREFIX_MAX
                                                                : item.prefix_len;
        end
        in_eff_key = item.field_key;
        in_check   = 1'b1;
        if (item.kind == paf_pkg::KIND_FIELD)
        begin
            if (in_port)
            begin
                if (in_udp)
                begin
                    in_eff_key = paf_pkg::KEY_UDP_SRC + {3'd0, item.field_key[0]};
                end
                else if (in_tcp)
                begin
                    in_eff_key = paf_pkg::KEY_TCP_SRC + {3'd0, item.field_key[0]};
                end
                else
                begin
                    in_check = 1'b0;
                end
            end
            else if (item.field_key > paf_pkg::KEY_TCP_DST)
            begin
                in_check = 1'b0;
            end
        end
    end

    // Operation register, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_kind_reg   <= item.kind;
            op_list_reg   <= item.list_sel;
            op_key_reg    <= in_eff_key;
            op_value_reg  <= in_value;
            op_prefix_reg <= in_prefix;
            op_check_reg  <= in_check;
            op_last_reg   <= item.last_field;
        end
    end

    // Rule memories: one read per list per cycle, one write at commit
    always_ff @(posedge clk)
    begin
        rd_white_reg <= white_mem[idx_reg];
        rd_black_reg <= black_mem[idx_reg];
        rd_idx_reg   <= idx_reg;
        if (wr_en && !op_list_reg)
        begin
            white_mem[wr_addr] <= wr_rule;
        end
        if (wr_en && op_list_reg)
        begin
            black_mem[wr_addr] <= wr_rule;
        end
    end

    // Match accumulation over the entry read in the previous cycle
    always_comb
    begin
        white_live = rd_valid_reg && op_check_reg &&
                     (CNT_W'(rd_idx_reg) < white_count_reg);
        black_live = rd_valid_reg && op_check_reg &&
                     (CNT_W'(rd_idx_reg) < black_count_reg);
        hit_w_next = hit_w_reg || (white_live && entry_match(rd_white_reg, is_add,
                     op_key_reg, op_value_reg, op_prefix_reg));
        hit_b_next = hit_b_reg || (black_live && entry_match(rd_black_reg, is_add,
                     op_key_reg, op_value_reg, op_prefix_reg));
        if (in_fire)
        begin
            hit_w_next = 1'b0;
            hit_b_next = 1'b0;
        end
    end

    // Commit decisions for additions and header fields
    always_comb
    begin
        is_add    = (op_kind_reg == paf_pkg::KIND_ADD);
        is_field  = (op_kind_reg == paf_pkg::KIND_FIELD);
        sel_count = op_list_reg ? black_count_reg : white_count_reg;
        dup       = op_list_reg ? hit_b_reg : hit_w_reg;
        full      = (sel_count == CNT_FULL);
        wr_en     = cmd.commit && is_add && !dup && !full;
        wr_addr   = sel_count[IDX_W-1:0];
        wr_rule   = '{key: op_key_reg, prefix: op_prefix_reg, value: op_value_reg};
        ws        = white_seen_reg || hit_w_reg;
        bs        = black_seen_reg || hit_b_reg;
        proto_sat = (op_value_reg > 48'(paf_pkg::PROTO_MAX)) ? paf_pkg::PROTO_MAX
                                                             : op_value_reg[7:0];
    end

    // Next values of the list counts, packet state and result register
    always_comb
    begin
        white_count_next = white_count_reg;
        black_count_next = black_count_reg;
        white_seen_next  = white_seen_reg;
        black_seen_next  = black_seen_reg;
        proto_next       = proto_reg;
        proto_known_next = proto_known_reg;
        out_valid_next   = out_valid_reg && !verdict.ready;
        out_status_next  = out_status_reg;
        out_white_next   = out_white_reg;
        out_black_next   = out_black_reg;

        if (in_fire && (item.kind == paf_pkg::KIND_CLEAR))
        begin
            white_count_next = '0;
            black_count_next = '0;
        end

        if (cmd.commit && is_add)
        begin
            out_valid_next = 1'b1;
            out_white_next = 1'b0;
            out_black_next = 1'b0;
            if (dup)
            begin
                out_status_next = paf_pkg::STATUS_PRESENT;
            end
            else if (full)
            begin
                out_status_next = paf_pkg::STATUS_FULL;
            end
            else
            begin
                out_status_next = paf_pkg::STATUS_STORED;
                if (op_list_reg)
                begin
                    black_count_next = black_count_reg + CNT_W'(1);
                end
                else
                begin
                    white_count_next = white_count_reg + CNT_W'(1);
                end
            end
        end

        if (cmd.commit && is_field)
        begin
            if (op_last_reg)
            begin
                out_valid_next  = 1'b1;
                out_white_next  = ws;
                out_black_next  = bs;
                out_status_next = (((white_count_reg == '0) || ws) &&
                                   ((black_count_reg == '0) || !bs))
                                  ? paf_pkg::STATUS_PASSED : paf_pkg::STATUS_FILTERED;
                white_seen_next  = 1'b0;
                black_seen_next  = 1'b0;
                proto_next       = '0;
                proto_known_next = 1'b0;
            end
            else
            begin
                white_seen_next = ws;
                black_seen_next = bs;
                if (op_key_reg == paf_pkg::KEY_IPPROTO)
                begin
                    proto_next       = proto_sat;
                    proto_known_next = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            rd_valid_reg    <= 1'b0;
            hit_w_reg       <= 1'b0;
            hit_b_reg       <= 1'b0;
            white_count_reg <= '0;
            black_count_reg <= '0;
            white_seen_reg  <= 1'b0;
            black_seen_reg  <= 1'b0;
            proto_reg       <= '0;
            proto_known_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            rd_valid_reg    <= cmd.scan;
            hit_w_reg       <= hit_w_next;
            hit_b_reg       <= hit_b_next;
            white_count_reg <= white_count_next;
            black_count_reg <= black_count_next;
            white_seen_reg  <= white_seen_next;
            black_seen_reg  <= black_seen_next;
            proto_reg       <= proto_next;
            proto_known_reg <= proto_known_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_white_reg  <= out_white_next;
        out_black_reg  <= out_black_next;
    end

endmodule

// ----- design/paf_checker.sv -----
// ----------------------------------------------------------------------------
// paf_checker: port-level checks of the packet ACL filter
// Watches the channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module paf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  in_kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic        out_white_hit,
    input logic        out_black_hit
);

    // No verdict is offered in the cycle after reset has been applied.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("verdict valid after reset");

    // A scanned transaction keeps the item channel closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_kind == paf_pkg::KIND_ADD || in_kind == paf_pkg::KIND_FIELD)
        |=> !in_ready)
        else $error("item accepted during a scan");

    // A stalled verdict holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) &&
        $stable(out_white_hit) && $stable(out_black_hit))
        else $error("stalled verdict changed");

    // Rule addition results carry no hit flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == paf_pkg::STATUS_STORED ||
                      out_status == paf_pkg::STATUS_PRESENT ||
                      out_status == paf_pkg::STATUS_FULL)
        |-> !out_white_hit && !out_black_hit)
        else $error("hit flag on a rule addition result");

endmodule

bind packet_acl_filter_unit paf_checker u_paf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .in_kind       (item.kind),
    .out_valid     (verdict.valid),
    .out_ready     (verdict.ready),
    .out_status    (verdict.status),
    .out_white_hit (verdict.white_hit),
    .out_black_hit (verdict.black_hit)
);

// ----- tb/packet_acl_filter_checker.sv -----
// ----------------------------------------------------------------------------
// packet_acl_filter_checker: verdict predictor and scoreboard
// Watches the item and verdict channels of the packet ACL filter. Every
// accepted item updates a private copy of the rule lists and packet state,
// and any verdict it causes is queued. Each accepted verdict transaction is
// compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module packet_acl_filter_checker #(
    parameter int RULES_PER_LIST = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    paf_item_if    item,
    paf_verdict_if verdict,
    output int     fail_count,
    output int     pending,
    output int     verdicts_seen,
    output int     packets_passed,
    output int     packets_filtered,
    output int     lists_full
);

    typedef struct packed {
        logic [2:0] status;
        logic       white_hit;
        logic       black_hit;
    } verdict_t;

    localparam int WHITE = 0;
    localparam int BLACK = 1;

    // Queued verdicts, oldest first.
    verdict_t    expected_verdicts [$];

    // Private copy of the rule lists and of the current packet.
    paf_pkg::rule_t acl_rules [2][RULES_PER_LIST];
    int          rule_count [2] = '{0, 0};
    logic        white_seen = 1'b0;
    logic        black_seen = 1'b0;
    logic [7:0]  packet_proto = '0;
    logic        proto_known = 1'b0;

    int          errors = 0;
    int          n_checked = 0;
    int          n_passed = 0;
    int          n_filtered = 0;
    int          n_full = 0;

    // True when some rule of the list matches the key and value.
    function automatic logic list_hit(input int lst, input logic [3:0] key,
                                      input logic [47:0] value);
        logic [31:0] net_mask;
        logic        hit;
        hit = 1'b0;
        for (int i = 0; i < rule_count[lst]; i++)
        begin
            if (acl_rules[lst][i].key == key)
            begin
                if (key == paf_pkg::KEY_IPSRC || key == paf_pkg::KEY_IPDST)
                begin
                    // Only the top prefix bits of the address take part.
                    net_mask = ~(32'hFFFF_FFFF >> acl_rules[lst][i].prefix);
                    if (((acl_rules[lst][i].value[31:0] ^ value[31:0]) & net_mask) == 32'd0)
                    begin
                        hit = 1'b1;
                    end
                end
                else if (acl_rules[lst][i].value == value)
                begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    // Apply one accepted item and queue the verdict it causes, if any.
    task automatic filter_item();
        paf_pkg::rule_t fresh;
        verdict_t   want;
        int         lst;
        logic       dup;
        logic       check;
        logic [3:0] eff_key;
        case (item.kind)
            paf_pkg::KIND_ADD:
            begin
                lst = int'(item.list_sel);
                fresh.key = item.field_key;
                if (item.field_key == paf_pkg::KEY_IPSRC ||
                    item.field_key == paf_pkg::KEY_IPDST)
                begin
                    fresh.value  = {16'd0, item.field_value[31:0]};
                    fresh.prefix = (item.prefix_len > paf_pkg::PREFIX_MAX)
                                   ? paf_pkg::PREFIX_MAX : item.prefix_len;
                end
                else
                begin
                    fresh.value  = item.field_value;
                    fresh.prefix = '0;
                end
                dup = 1'b0;
                for (int i = 0; i < rule_count[lst]; i++)
                begin
                    if (acl_rules[lst][i] == fresh)
                    begin
                        dup = 1'b1;
                    end
                end
                // A duplicate is reported even when the list is full.
                if (dup)
                begin
                    want.status = paf_pkg::STATUS_PRESENT;
                end
                else if (rule_count[lst] >= RULES_PER_LIST)
                begin
                    want.status = paf_pkg::STATUS_FULL;
                end
                else
                begin
                    acl_rules[lst][rule_count[lst]] = fresh;
                    rule_count[lst]++;
                    want.status = paf_pkg::STATUS_STORED;
                end
                want.white_hit = 1'b0;
                want.black_hit = 1'b0;
                expected_verdicts = {expected_verdicts, want};
            end
            paf_pkg::KIND_CLEAR:
            begin
                // The packet in progress keeps its state.
                rule_count[WHITE] = 0;
                rule_count[BLACK] = 0;
            end
            paf_pkg::KIND_FIELD:
            begin
                eff_key = item.field_key;
                check   = 1'b1;
                if (item.field_key == paf_pkg::KEY_IPPROTO)
                begin
                    packet_proto = (item.field_value > 48'd255) ? paf_pkg::PROTO_MAX
                                                                : item.field_value[7:0];
                    proto_known  = 1'b1;
                end
                else if (item.field_key >= paf_pkg::KEY_UDP_SRC &&
                         item.field_key <= paf_pkg::KEY_TCP_DST)
                begin
                    // Ports are looked up as UDP or TCP by the packet protocol.
                    if (proto_known && packet_proto == paf_pkg::PROTO_UDP)
                    begin
                        eff_key = paf_pkg::KEY_UDP_SRC | {3'd0, item.field_key[0]};
                    end
                    else if (proto_known && packet_proto == paf_pkg::PROTO_TCP)
                    begin
                        eff_key = paf_pkg::KEY_TCP_SRC | {3'd0, item.field_key[0]};
                    end
                    else
                    begin
                        check = 1'b0;
                    end
                end
                else if (item.field_key > paf_pkg::KEY_TCP_DST)
                begin
                    check = 1'b0;
                end
                if (check)
                begin
                    if (list_hit(WHITE, eff_key, item.field_value))
                    begin
                        white_seen = 1'b1;
                    end
                    if (list_hit(BLACK, eff_key, item.field_value))
                    begin
                        black_seen = 1'b1;
                    end
                end
                if (item.last_field)
                begin
                    want.status = ((rule_count[WHITE] == 0 || white_seen) &&
                                   (rule_count[BLACK] == 0 || !black_seen))
                                  ? paf_pkg::STATUS_PASSED : paf_pkg::STATUS_FILTERED;
                    want.white_hit = white_seen;
                    want.black_hit = black_seen;
                    expected_verdicts = {expected_verdicts, want};
                    white_seen   = 1'b0;
                    black_seen   = 1'b0;
                    packet_proto = '0;
                    proto_known  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Compare verdicts first, then apply the item accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            rule_count[WHITE] = 0;
            rule_count[BLACK] = 0;
            white_seen        = 1'b0;
            black_seen        = 1'b0;
            packet_proto      = '0;
            proto_known       = 1'b0;
            expected_verdicts.delete();
            fail_count       <= 0;
            pending          <= 0;
            verdicts_seen    <= 0;
            packets_passed   <= 0;
            packets_filtered <= 0;
            lists_full       <= 0;
        end
        else
        begin
            if (verdict.valid && verdict.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected verdict transaction: status %0d", verdict.status);
                    errors++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    n_checked++;
                    if (want.status == paf_pkg::STATUS_PASSED)
                    begin
                        n_passed++;
                    end
                    if (want.status == paf_pkg::STATUS_FILTERED)
                    begin
                        n_filtered++;
                    end
                    if (want.status == paf_pkg::STATUS_FULL)
                    begin
                        n_full++;
                    end
                    if (verdict.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, verdict.status);
                        errors++;
                    end
                    if (verdict.white_hit !== want.white_hit)
                    begin
                        $error("white_hit: expected %0d, got %0d",
                               want.white_hit, verdict.white_hit);
                        errors++;
                    end
                    if (verdict.black_hit !== want.black_hit)
                    begin
                        $error("black_hit: expected %0d, got %0d",
                               want.black_hit, verdict.black_hit);
                        errors++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                filter_item();
            end
            fail_count       <= errors;
            pending          <= expected_verdicts.size();
            verdicts_seen    <= n_checked;
            packets_passed   <= n_passed;
            packets_filtered <= n_filtered;
            lists_full       <= n_full;
        end
    end

endmodule

// ----- tb/packet_acl_filter_unit_test.sv -----
// ----------------------------------------------------------------------------
// packet_acl_filter_unit_test: testbench top of the packet ACL filter
// Drives directed rule and packet transactions, then random rule traffic and
// well-formed packets with some noise, under three idling patterns on the
// two channels. The checker beside the block predicts and compares verdicts.
// ----------------------------------------------------------------------------
module packet_acl_filter_unit_test;

    localparam int         RULES_PER_LIST  = 16;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         SETTLE_CYCLES   = RULES_PER_LIST + 4;
    localparam int         ITEMS_PER_PHASE = 410;
    localparam logic [1:0] KIND_UNUSED     = 2'd3;
    localparam logic [3:0] KEY_ETHSRC      = 4'd0;
    localparam logic [3:0] KEY_ETHDST      = 4'd1;
    localparam logic [3:0] KEY_UDP_DST     = 4'd9;
    localparam logic [3:0] KEY_SPARE       = 4'd13;
    localparam logic [3:0] KEY_TOP         = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int          send_idle = 34;
    int          recv_idle = 71;
    int          cycles = 0;
    int          items_sent = 0;
    int          fail_count;
    int          pending;
    int          verdicts_seen;
    int          packets_passed;
    int          packets_filtered;
    int          lists_full;
    logic [47:0] value_pool [16][4];

    paf_item_if    item_ch ();
    paf_verdict_if verdict_ch ();

    packet_acl_filter_unit #(
        .RULES_PER_LIST(RULES_PER_LIST)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .verdict(verdict_ch)
    );

    packet_acl_filter_checker #(
        .RULES_PER_LIST(RULES_PER_LIST)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .verdict         (verdict_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .verdicts_seen   (verdicts_seen),
        .packets_passed  (packets_passed),
        .packets_filtered(packets_filtered),
        .lists_full      (lists_full)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random.
    always @(posedge clk)
    begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item, with random idle cycles first, and wait for its transaction.
    task automatic offer_item(input logic [1:0] kind, input logic sel, input logic [3:0] key,
                              input logic [47:0] value, input logic [5:0] prefix,
                              input logic last);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.list_sel    <= sel;
        item_ch.field_key   <= key;
        item_ch.field_value <= value;
        item_ch.prefix_len  <= prefix;
        item_ch.last_field  <= last;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        if (kind != KIND_UNUSED)
        begin
            items_sent++;
        end
    endtask

    // Hold off until every queued verdict has come and the block has settled.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] random_value();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Keys above eleven are kept rare, since they never match.
    function automatic logic [3:0] pick_key();
        if ($urandom_range(0, 19) < 18)
        begin
            return 4'($urandom_range(0, 11));
        end
        return 4'($urandom_range(12, 15));
    endfunction

    // Mostly legal IPv4 prefixes, sometimes over-long ones.
    function automatic logic [5:0] pick_prefix();
        if ($urandom_range(0, 9) == 0)
        begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(0, 32));
    endfunction

    // Values mostly from a small pool per key, so rules and fields meet.
    function automatic logic [47:0] pool_value(input logic [3:0] key);
        if ($urandom_range(0, 4) == 0)
        begin
            return random_value();
        end
        return value_pool[key][$urandom_range(0, 3)];
    endfunction

    // Random rule changes and packets; a few packets lose their last field.
    task automatic random_traffic(input int count);
        int          target;
        int          pick;
        int          n_fields;
        logic [3:0]  key;
        logic [47:0] value;
        logic        last;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                offer_item(paf_pkg::KIND_CLEAR, 1'($urandom), 4'($urandom), random_value(),
                           6'($urandom), 1'($urandom));
            end
            else if (pick < 6)
            begin
                offer_item(KIND_UNUSED, 1'($urandom), 4'($urandom), random_value(),
                           6'($urandom), 1'($urandom));
            end
            else if (pick < 30)
            begin
                key = pick_key();
                offer_item(paf_pkg::KIND_ADD, 1'($urandom), key, pool_value(key),
                           pick_prefix(), 1'($urandom));
            end
            else
            begin
                n_fields = $urandom_range(1, 6);
                for (int f = 0; f < n_fields; f++)
                begin
                    if (f == 0 && $urandom_range(0, 9) < 6)
                    begin
                        key = paf_pkg::KEY_IPPROTO;
                        case ($urandom_range(0, 4))
                            0, 1:    value = {40'd0, paf_pkg::PROTO_TCP};
                            2, 3:    value = {40'd0, paf_pkg::PROTO_UDP};
                            default: value = random_value();
                        endcase
                    end
                    else
                    begin
                        key   = pick_key();
                        value = pool_value(key);
                        if (key == paf_pkg::KEY_IPSRC || key == paf_pkg::KEY_IPDST)
                        begin
                            // Disturb the host part so prefixes of all lengths are tried.
                            value = value ^ (random_value() &
                                             ((48'd1 << $urandom_range(0, 32)) - 48'd1));
                        end
                    end
                    last = (f == n_fields - 1) && ($urandom_range(0, 19) != 0);
                    offer_item(paf_pkg::KIND_FIELD, 1'($urandom), key, value, 6'($urandom),
                               last);
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        item_ch.valid       = 1'b0;
        item_ch.kind        = paf_pkg::KIND_ADD;
        item_ch.list_sel    = 1'b0;
        item_ch.field_key   = '0;
        item_ch.field_value = '0;
        item_ch.prefix_len  = '0;
        item_ch.last_field  = 1'b0;
        verdict_ch.ready    = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                value_pool[k][j] = random_value();
            end
        end
        value_pool[paf_pkg::KEY_IPPROTO][0] = {40'd0, paf_pkg::PROTO_TCP};
        value_pool[paf_pkg::KEY_IPPROTO][1] = {40'd0, paf_pkg::PROTO_UDP};
        value_pool[paf_pkg::KEY_IPPROTO][2] = {40'd0, paf_pkg::PROTO_MAX};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Packets against empty lists pass.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, KEY_ETHSRC, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1);
        offer_item(paf_pkg::KIND_FIELD, 1'b1, KEY_ETHDST, 48'h0, 6'd0, 1'b1);
        // IPv4 rules drop the upper value bits and saturate the prefix.
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_IPSRC, 48'hFFFF_0A00_0000, 6'd8,
                   1'b1);
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_IPSRC, 48'h0000_0A00_0000, 6'd8,
                   1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_IPDST, 48'h0000_C0A8_0101, 6'd63,
                   1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_IPDST, 48'h0000_C0A8_0101, 6'd32,
                   1'b0);
        // Other keys store no prefix, so these two are the same rule.
        offer_item(paf_pkg::KIND_ADD, 1'b1, KEY_ETHSRC, 48'h0200_0000_0001, 6'd17, 1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b1, KEY_ETHSRC, 48'h0200_0000_0001, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_TCP_DST, 48'd80, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b0, paf_pkg::KEY_UDP_SRC, 48'd53, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_ADD, 1'b1, KEY_SPARE, 48'd7, 6'd0, 1'b0);
        // Prefix match that uses only the low 32 bits of the field value.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPSRC, 48'hFFFF_0AFF_1234, 6'd0,
                   1'b1);
        // A UDP destination key under TCP is looked up as a TCP port.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPPROTO,
                   {40'd0, paf_pkg::PROTO_TCP}, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, KEY_UDP_DST, 48'd80, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, KEY_ETHSRC, 48'h0200_0000_0001, 6'd0, 1'b1);
        // A port before any protocol field, then an over-range protocol.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_TCP_DST, 48'd80, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPPROTO, 48'd300, 6'd0, 1'b1);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPPROTO,
                   {40'd0, paf_pkg::PROTO_UDP}, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_TCP_SRC, 48'd53, 6'd0, 1'b1);
        // A stored rule with a key above eleven never matches.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, KEY_SPARE, 48'd7, 6'd0, 1'b1);
        offer_item(KIND_UNUSED, 1'b1, KEY_TOP, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1);
        // A zero prefix matches every address.
        offer_item(paf_pkg::KIND_ADD, 1'b1, paf_pkg::KEY_IPDST, 48'h0, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPDST, 48'hFFFF_FFFF_FFFF, 6'd0,
                   1'b1);
        // A clear in mid-packet keeps the packet protocol.
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_IPPROTO,
                   {40'd0, paf_pkg::PROTO_UDP}, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_CLEAR, 1'b1, KEY_TOP, 48'hFFFF_FFFF_FFFF, 6'd63, 1'b1);
        offer_item(paf_pkg::KIND_ADD, 1'b0, KEY_UDP_DST, 48'd443, 6'd0, 1'b0);
        offer_item(paf_pkg::KIND_FIELD, 1'b0, paf_pkg::KEY_TCP_DST, 48'd443, 6'd0, 1'b1);
        wait_idle();

        random_traffic(ITEMS_PER_PHASE);
        wait_idle();
        send_idle = 71;
        recv_idle = 34;
        random_traffic(ITEMS_PER_PHASE);
        wait_idle();
        send_idle = 0;
        recv_idle = 0;
        random_traffic(ITEMS_PER_PHASE);
        wait_idle();

        $display("summary: %0d items in %0d cycles, %0d verdicts checked",
                 items_sent, cycles, verdicts_seen);
        $display("summary: %0d packets passed, %0d filtered, %0d rules refused on a full list",
                 packets_passed, packets_filtered, lists_full);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
